/* src/gsi_pkg.sv */
// ----------------------------------------------------------------------------
// gsi_pkg
// Shared types, codes and helpers for the gradient stop interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package gsi_pkg;

  localparam int MaxStops   = 16;
  localparam int IdxW       = $clog2(MaxStops);
  localparam int CntW       = IdxW + 1;
  localparam int BlendSteps = 16;
  localparam int RatioSteps = 48;
  localparam int DivCntW    = 6;

  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_START   = 2'd1,
    CMD_SEGMENT = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_e;

  typedef enum logic {
    REG_UNIT_MODE  = 1'b0,
    REG_STOP_COUNT = 1'b1
  } reg_e;

  typedef enum logic [1:0] {
    KIND_RGBA   = 2'd0,
    KIND_RGB    = 2'd1,
    KIND_ALPHA  = 2'd2,
    KIND_WEIGHT = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    CH_COLOUR = 2'd0,
    CH_ALPHA  = 2'd1,
    CH_WEIGHT = 2'd2
  } chan_e;

  typedef enum logic [2:0] {
    COMP_RED    = 3'd0,
    COMP_GREEN  = 3'd1,
    COMP_BLUE   = 3'd2,
    COMP_ALPHA  = 3'd3,
    COMP_WEIGHT = 3'd4
  } comp_e;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic prep_ratio;
    logic set_p_raw;
    logic set_p_ratio;
    logic path_clear;
    logic chan_first;
    logic search_up;
    logic search_down;
    logic search_last;
    logic mul1;
    logic mul2;
    logic store_direct;
    logic store_div;
    logic out_load;
  } gsi_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic cmd_load;
    logic cmd_start;
    logic cmd_seg;
    logic unit_raw;
    logic few_stops;
    logic div_busy;
    logic up_end;
    logic up_hit;
    logic dn_hit;
    logic idx_zero;
    logic last_hit;
    logic direct;
    logic comp_last;
    logic chan_last;
    logic final_seg;
    logic out_busy;
  } gsi_status_t;

  function automatic logic kind_match(chan_e ch, logic [1:0] kind);
    logic m;
    case (ch)
      CH_COLOUR: m = (kind == KIND_RGBA) || (kind == KIND_RGB);
      CH_ALPHA:  m = (kind == KIND_RGBA) || (kind == KIND_ALPHA);
      CH_WEIGHT: m = (kind == KIND_WEIGHT);
      default:   m = 1'b0;
    endcase
    return m;
  endfunction

  function automatic comp_e first_comp(chan_e ch);
    comp_e c;
    case (ch)
      CH_COLOUR: c = COMP_RED;
      CH_ALPHA:  c = COMP_ALPHA;
      default:   c = COMP_WEIGHT;
    endcase
    return c;
  endfunction

  // pick one component out of a stored stop word
  function automatic logic [15:0] comp_sel(logic [31:0] w, comp_e c);
    logic [15:0] v;
    case (c)
      COMP_RED:    v = {8'd0, w[31:24]};
      COMP_GREEN:  v = {8'd0, w[23:16]};
      COMP_BLUE:   v = {8'd0, w[15:8]};
      COMP_ALPHA:  v = {8'd0, w[7:0]};
      default:     v = w[15:0];
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

/* src/gsi_ctrl.sv */
// ----------------------------------------------------------------------------
// gsi_ctrl
// Sequencer: accepts requests, runs ratio division, stop search per channel,
// blend per component and hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module gsi_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  gsi_pkg::gsi_status_t status_i,
  output gsi_pkg::gsi_cmd_t   cmd_o
);
  import gsi_pkg::*;

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b000_0000_0001,
    ST_PREP  = 11'b000_0000_0010,
    ST_RDIV  = 11'b000_0000_0100,
    ST_CHECK = 11'b000_0000_1000,
    ST_UP    = 11'b000_0001_0000,
    ST_DOWN  = 11'b000_0010_0000,
    ST_LAST  = 11'b000_0100_0000,
    ST_BLEND = 11'b000_1000_0000,
    ST_MUL2  = 11'b001_0000_0000,
    ST_DIV   = 11'b010_0000_0000,
    ST_OUT   = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (status_i.cmd_seg) begin
            state_d = ST_PREP;
          end
        end
      end
      ST_PREP: begin
        if (status_i.unit_raw) begin
          cmd_o.set_p_raw = 1'b1;
          state_d = ST_CHECK;
        end else begin
          cmd_o.prep_ratio = 1'b1;
          state_d = ST_RDIV;
        end
      end
      ST_RDIV: begin
        if (!status_i.div_busy) begin
          cmd_o.set_p_ratio = 1'b1;
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status_i.few_stops) begin
          cmd_o.path_clear = status_i.final_seg;
          state_d = ST_IDLE;
        end else begin
          cmd_o.chan_first = 1'b1;
          state_d = ST_UP;
        end
      end
      ST_UP: begin
        cmd_o.search_up = 1'b1;
        if (status_i.up_end) begin
          state_d = ST_LAST;
        end else if (status_i.up_hit) begin
          state_d = ST_DOWN;
        end
      end
      ST_DOWN: begin
        cmd_o.search_down = 1'b1;
        if (status_i.dn_hit || status_i.idx_zero) begin
          state_d = ST_BLEND;
        end
      end
      ST_LAST: begin
        cmd_o.search_last = 1'b1;
        if (status_i.last_hit || status_i.idx_zero) begin
          state_d = ST_BLEND;
        end
      end
      ST_BLEND: begin
        if (status_i.direct) begin
          cmd_o.store_direct = 1'b1;
          if (!status_i.comp_last) begin
            state_d = ST_BLEND;
          end else if (status_i.chan_last) begin
            state_d = ST_OUT;
          end else begin
            state_d = ST_UP;
          end
        end else begin
          cmd_o.mul1 = 1'b1;
          state_d = ST_MUL2;
        end
      end
      ST_MUL2: begin
        cmd_o.mul2 = 1'b1;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (!status_i.div_busy) begin
          cmd_o.store_div = 1'b1;
          if (!status_i.comp_last) begin
            state_d = ST_BLEND;
          end else if (status_i.chan_last) begin
            state_d = ST_OUT;
          end else begin
            state_d = ST_UP;
          end
        end
      end
      ST_OUT: begin
        if (!status_i.out_busy) begin
          cmd_o.out_load   = 1'b1;
          cmd_o.path_clear = status_i.final_seg;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* src/gsi_dp.sv */
// ----------------------------------------------------------------------------
// gsi_dp
// Datapath: stop table, registers, distance accumulator, shared serial
// divider, channel search pointers, blend multiplier and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module gsi_dp (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  cfg_valid_i,
  input  wire                  cfg_index_i,
  input  wire  [4:0]           cfg_data_i,
  input  wire  [1:0]           command_i,
  input  wire  [3:0]           stop_index_i,
  input  wire  [1:0]           stop_kind_i,
  input  wire  [31:0]          stop_pos_i,
  input  wire  [7:0]           stop_red_i,
  input  wire  [7:0]           stop_green_i,
  input  wire  [7:0]           stop_blue_i,
  input  wire  [7:0]           stop_alpha_i,
  input  wire  [15:0]          stop_weight_i,
  input  wire  [31:0]          path_total_i,
  input  wire  [31:0]          seg_length_i,
  input  wire                  final_segment_i,
  input  gsi_pkg::gsi_cmd_t    cmd_i,
  output gsi_pkg::gsi_status_t status_o,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output logic [7:0]           out_red_o,
  output logic [7:0]           out_green_o,
  output logic [7:0]           out_blue_o,
  output logic [7:0]           out_alpha_o,
  output logic [15:0]          out_weight_o,
  output logic                 end_of_path_o
);
  import gsi_pkg::*;

  // configuration
  logic            unit_mode_q;
  logic [CntW-1:0] stop_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_mode_q  <= 1'b0;
      stop_count_q <= '0;
    end else if (cfg_valid_i) begin
      case (reg_e'(cfg_index_i))
        REG_UNIT_MODE:  unit_mode_q  <= cfg_data_i[0];
        REG_STOP_COUNT: stop_count_q <= cfg_data_i[CntW-1:0];
        default: ;
      endcase
    end
  end

  logic [CntW-1:0] n;
  assign n = (stop_count_q > CntW'(MaxStops)) ? CntW'(MaxStops) : stop_count_q;

  // stop table
  logic [1:0]  kind_mem [MaxStops];
  logic [31:0] pos_mem  [MaxStops];
  logic [31:0] col_mem  [MaxStops];
  logic [15:0] wt_mem   [MaxStops];

  logic is_load, is_start, is_seg;
  assign is_load  = cmd_i.accept && (command_i == CMD_LOAD);
  assign is_start = cmd_i.accept && (command_i == CMD_START);
  assign is_seg   = cmd_i.accept && (command_i == CMD_SEGMENT);

  always_ff @(posedge clk_i) begin
    if (is_load) begin
      kind_mem[stop_index_i[IdxW-1:0]] <= stop_kind_i;
      pos_mem[stop_index_i[IdxW-1:0]]  <= stop_pos_i;
      col_mem[stop_index_i[IdxW-1:0]]  <=
        {stop_red_i, stop_green_i, stop_blue_i, stop_alpha_i};
      wt_mem[stop_index_i[IdxW-1:0]]   <= stop_weight_i;
    end
  end

  // path state
  logic [31:0] sum_q, total_q, p_q;
  logic        final_q;
  logic [32:0] sum_wide;
  logic [31:0] sum_sat;

  assign sum_wide = {1'b0, sum_q} + {1'b0, seg_length_i};
  assign sum_sat  = sum_wide[32] ? 32'hFFFF_FFFF : sum_wide[31:0];

  // serial divider, shared by ratio and blend
  logic [31:0]        rem_q, div_q;
  logic [47:0]        quo_q;
  logic [DivCntW-1:0] cnt_q;
  logic [32:0]        shifted;
  logic               ge;
  logic [32:0]        diff;

  assign shifted = {rem_q, quo_q[47]};
  assign ge      = shifted >= {1'b0, div_q};
  assign diff    = shifted - {1'b0, div_q};

  // channel search
  chan_e           ch_q;
  comp_e           comp_q;
  logic [CntW-1:0] idx_q;
  logic [CntW-1:0] cursor_q [3];
  logic [31:0]     hi_pos_q, lo_pos_q, hi_val_q, lo_val_q;
  logic            absent_q;
  logic [47:0]     prod_q;

  logic [1:0]  rd_kind;
  logic [31:0] rd_pos, rd_val;
  logic        match;
  logic        up_end, up_hit, dn_hit, idx_zero, comp_last, chan_last;
  chan_e       next_ch;
  logic [15:0] a_val, b_val;
  logic        direct;
  logic [47:0] mul_a, mul_b, num;

  assign rd_kind  = kind_mem[idx_q[IdxW-1:0]];
  assign rd_pos   = pos_mem[idx_q[IdxW-1:0]];
  assign rd_val   = (ch_q == CH_WEIGHT) ? {16'd0, wt_mem[idx_q[IdxW-1:0]]}
                                        : col_mem[idx_q[IdxW-1:0]];
  assign match    = kind_match(ch_q, rd_kind);
  assign up_end   = idx_q >= n;
  assign up_hit   = !up_end && match && (p_q <= rd_pos);
  assign dn_hit   = match && (p_q >= rd_pos);
  assign idx_zero = (idx_q == '0);
  assign comp_last = (ch_q != CH_COLOUR) || (comp_q == COMP_BLUE);
  assign chan_last = (ch_q == CH_WEIGHT);
  assign next_ch   = chan_e'(ch_q + 2'd1);
  assign a_val     = comp_sel(lo_val_q, comp_q);
  assign b_val     = comp_sel(hi_val_q, comp_q);
  assign direct    = absent_q || (hi_pos_q == lo_pos_q);
  assign mul_a     = (hi_pos_q - p_q) * a_val;
  assign mul_b     = (p_q - lo_pos_q) * b_val;
  assign num       = prod_q + mul_b;

  logic        store;
  logic [15:0] store_val;
  assign store     = cmd_i.store_direct || cmd_i.store_div;
  assign store_val = cmd_i.store_div ? quo_q[15:0] : (absent_q ? 16'd0 : b_val);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      total_q <= 32'd1;
      final_q <= 1'b0;
    end else begin
      if (is_start) begin
        total_q <= (path_total_i == 32'd0) ? 32'd1 : path_total_i;
      end
      if (is_seg) begin
        final_q <= final_segment_i;
      end
      if (is_start || cmd_i.path_clear) begin
        sum_q <= '0;
      end else if (is_seg) begin
        sum_q <= sum_sat;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.set_p_raw) begin
      p_q <= sum_q;
    end else if (cmd_i.set_p_ratio) begin
      p_q <= (|quo_q[47:32]) ? 32'hFFFF_FFFF : quo_q[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.prep_ratio) begin
      cnt_q <= DivCntW'(RatioSteps);
    end else if (cmd_i.mul2) begin
      cnt_q <= DivCntW'(BlendSteps);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  // blend division starts with the top part, which is already below the span
  always_ff @(posedge clk_i) begin
    if (cmd_i.prep_ratio) begin
      rem_q <= '0;
      quo_q <= {sum_q, 16'd0};
      div_q <= total_q;
    end else if (cmd_i.mul2) begin
      rem_q <= num[47:16];
      quo_q <= {num[15:0], 32'd0};
      div_q <= hi_pos_q - lo_pos_q;
    end else if (cnt_q != '0) begin
      rem_q <= ge ? diff[31:0] : shifted[31:0];
      quo_q <= {quo_q[46:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        cursor_q[i] <= '0;
      end
      ch_q     <= CH_COLOUR;
      comp_q   <= COMP_RED;
      idx_q    <= '0;
      absent_q <= 1'b0;
    end else begin
      if (is_start || cmd_i.path_clear) begin
        for (int i = 0; i < 3; i++) begin
          cursor_q[i] <= '0;
        end
      end else if (cmd_i.search_up && up_hit) begin
        cursor_q[ch_q] <= idx_q;
      end

      if (cmd_i.chan_first) begin
        ch_q     <= CH_COLOUR;
        comp_q   <= COMP_RED;
        idx_q    <= cursor_q[CH_COLOUR];
        absent_q <= 1'b0;
      end else if (store) begin
        if (comp_last) begin
          if (!chan_last) begin
            ch_q     <= next_ch;
            comp_q   <= first_comp(next_ch);
            idx_q    <= cursor_q[next_ch];
            absent_q <= 1'b0;
          end
        end else begin
          comp_q <= comp_e'(comp_q + 3'd1);
        end
      end else if (cmd_i.search_up) begin
        if (up_end) begin
          idx_q <= n - 1'b1;
        end else if (!up_hit) begin
          idx_q <= idx_q + 1'b1;
        end
      end else if (cmd_i.search_down) begin
        if (!dn_hit && !idx_zero) begin
          idx_q <= idx_q - 1'b1;
        end
      end else if (cmd_i.search_last) begin
        if (!match && !idx_zero) begin
          idx_q <= idx_q - 1'b1;
        end else if (!match) begin
          absent_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.search_up && up_hit) begin
      hi_pos_q <= rd_pos;
      hi_val_q <= rd_val;
    end else if (cmd_i.search_last && match) begin
      hi_pos_q <= rd_pos;
      hi_val_q <= rd_val;
    end
    // no lower stop: lower takes the upper one
    if ((cmd_i.search_down && dn_hit) || (cmd_i.search_last && match)) begin
      lo_pos_q <= rd_pos;
      lo_val_q <= rd_val;
    end else if (cmd_i.search_down && idx_zero) begin
      lo_pos_q <= hi_pos_q;
      lo_val_q <= hi_val_q;
    end
    if (cmd_i.mul1) begin
      prod_q <= mul_a;
    end
  end

  // result collection and output register
  logic [7:0]  res_r_q, res_g_q, res_b_q, res_a_q;
  logic [15:0] res_w_q;
  logic        out_valid_q;

  always_ff @(posedge clk_i) begin
    if (store) begin
      case (comp_q)
        COMP_RED:   res_r_q <= store_val[7:0];
        COMP_GREEN: res_g_q <= store_val[7:0];
        COMP_BLUE:  res_b_q <= store_val[7:0];
        COMP_ALPHA: res_a_q <= store_val[7:0];
        default:    res_w_q <= store_val;
      endcase
    end
    if (cmd_i.out_load) begin
      out_red_o     <= res_r_q;
      out_green_o   <= res_g_q;
      out_blue_o    <= res_b_q;
      out_alpha_o   <= res_a_q;
      out_weight_o  <= res_w_q;
      end_of_path_o <= final_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  always_comb begin
    status_o           = '0;
    status_o.cmd_load  = (command_i == CMD_LOAD);
    status_o.cmd_start = (command_i == CMD_START);
    status_o.cmd_seg   = (command_i == CMD_SEGMENT);
    status_o.unit_raw  = unit_mode_q;
    status_o.few_stops = n < CntW'(2);
    status_o.div_busy  = (cnt_q != '0);
    status_o.up_end    = up_end;
    status_o.up_hit    = up_hit;
    status_o.dn_hit    = dn_hit;
    status_o.idx_zero  = idx_zero;
    status_o.last_hit  = match;
    status_o.direct    = direct;
    status_o.comp_last = comp_last;
    status_o.chan_last = chan_last;
    status_o.final_seg = final_q;
    status_o.out_busy  = out_valid_q && !out_ready_i;
  end

endmodule

`default_nettype wire

/* src/gradient_stop_interpolator.sv */
// ----------------------------------------------------------------------------
// gradient_stop_interpolator
// Multi-stop linear gradient along a polyline: colour, alpha and weight.
// ----------------------------------------------------------------------------
// Usage: request channel (in_valid_i/in_ready_o) carries a command: load a
// stop into the 16-entry table, start a path, or give a segment length.
// Config channel (cfg_valid_i/cfg_ready_o, always ready) writes unit_mode
// (index 0) and stop_count (index 1); the user must write them only while
// the block is idle, which the block does not enforce. Load and start
// requests are taken without leaving idle. A segment request runs the
// accumulator, in ratio mode a 48-step serial division, then per channel
// a stop search at one table entry per cycle on the single table read port
// and per component, unless the value is taken straight from a stop, a
// multiply (mul1, mul2) and a division on the shared one-bit-per-cycle
// divider. One request is worked on at a time.
// A result waits in the output register (out_valid_o/out_ready_i); a new
// request is taken meanwhile, but the next result waits for the register.
// Reset clears the configuration registers, accumulator, cursors and output
// valid; the stop table holds garbage until loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module gradient_stop_interpolator (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire         cfg_index_i,
  input  wire  [4:0]  cfg_data_i,
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  wire  [1:0]  command_i,
  input  wire  [3:0]  stop_index_i,
  input  wire  [1:0]  stop_kind_i,
  input  wire  [31:0] stop_pos_i,
  input  wire  [7:0]  stop_red_i,
  input  wire  [7:0]  stop_green_i,
  input  wire  [7:0]  stop_blue_i,
  input  wire  [7:0]  stop_alpha_i,
  input  wire  [15:0] stop_weight_i,
  input  wire  [31:0] path_total_i,
  input  wire  [31:0] seg_length_i,
  input  wire         final_segment_i,
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output logic [7:0]  out_red_o,
  output logic [7:0]  out_green_o,
  output logic [7:0]  out_blue_o,
  output logic [7:0]  out_alpha_o,
  output logic [15:0] out_weight_o,
  output logic        end_of_path_o
);
  import gsi_pkg::*;

  gsi_cmd_t    cmd;
  gsi_status_t status;

  assign cfg_ready_o = 1'b1;

  gsi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  gsi_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .command_i       (command_i),
    .stop_index_i    (stop_index_i),
    .stop_kind_i     (stop_kind_i),
    .stop_pos_i      (stop_pos_i),
    .stop_red_i      (stop_red_i),
    .stop_green_i    (stop_green_i),
    .stop_blue_i     (stop_blue_i),
    .stop_alpha_i    (stop_alpha_i),
    .stop_weight_i   (stop_weight_i),
    .path_total_i    (path_total_i),
    .seg_length_i    (seg_length_i),
    .final_segment_i (final_segment_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_red_o       (out_red_o),
    .out_green_o     (out_green_o),
    .out_blue_o      (out_blue_o),
    .out_alpha_o     (out_alpha_o),
    .out_weight_o    (out_weight_o),
    .end_of_path_o   (end_of_path_o)
  );

endmodule

`default_nettype wire

/* tb/gradient_stop_interpolator_test.sv */
// ----------------------------------------------------------------------------
// gradient_stop_interpolator_test
// Drives stop loads, path starts and segment requests into the interpolator
// and compares every colour, alpha and weight result against a predictor.
// ----------------------------------------------------------------------------
module gradient_stop_interpolator_test;
  timeunit 1ns;
  timeprecision 1ps;
  import gsi_pkg::*;

  typedef struct {
    cmd_e        cmd;
    logic [3:0]  idx;
    kind_e       kind;
    logic [31:0] pos;
    logic [7:0]  red, green, blue, alpha;
    logic [15:0] wt;
    logic [31:0] total;
    logic [31:0] seg;
    logic        fin;
  } req_t;

  typedef struct {
    logic [7:0]  red, green, blue, alpha;
    logic [15:0] wt;
    logic        eop;
  } pixel_t;

  typedef struct {
    req_t   req;
    bit     known;
    pixel_t pix;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i = 1'b0;
  logic [4:0]  cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  command_i = '0;
  logic [3:0]  stop_index_i = '0;
  logic [1:0]  stop_kind_i = '0;
  logic [31:0] stop_pos_i = '0;
  logic [7:0]  stop_red_i = '0, stop_green_i = '0, stop_blue_i = '0, stop_alpha_i = '0;
  logic [15:0] stop_weight_i = '0;
  logic [31:0] path_total_i = '0;
  logic [31:0] seg_length_i = '0;
  logic        final_segment_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  out_red_o, out_green_o, out_blue_o, out_alpha_o;
  logic [15:0] out_weight_o;
  logic        end_of_path_o;

  gradient_stop_interpolator i_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  kind_e       stop_kind_tbl [16];
  logic [31:0] stop_pos_tbl [16];
  logic [31:0] stop_col_tbl [16];
  logic [15:0] stop_wt_tbl [16];
  logic [31:0] dist_sum;
  logic [31:0] path_len;
  int          cursor [3];
  bit          raw_units;
  logic [4:0]  n_stops;

  pixel_t pending_pixels [$];
  int     errors;
  int     hold_cycles;
  bit     stim_done;

  function automatic bit kind_in_chan(int ch, kind_e k);
    case (ch)
      0: return k == KIND_RGBA || k == KIND_RGB;
      1: return k == KIND_RGBA || k == KIND_ALPHA;
      default: return k == KIND_WEIGHT;
    endcase
  endfunction

  // bracketing stops for one channel, moving its cursor forward
  function automatic bit bracket(int ch, logic [31:0] p, int n, output int lo, output int hi);
    int i;
    lo = 0;
    hi = -1;
    for (i = cursor[ch]; i < n; i++) begin
      if (kind_in_chan(ch, stop_kind_tbl[i]) && p <= stop_pos_tbl[i]) begin
        hi = i;
        break;
      end
    end
    if (hi < 0) begin
      // past the last stop: hold the highest matching one
      for (i = n - 1; i >= 0; i--) begin
        if (kind_in_chan(ch, stop_kind_tbl[i])) begin
          lo = i;
          hi = i;
          return 1;
        end
      end
      return 0;
    end
    cursor[ch] = hi;
    lo = hi;
    for (i = hi; i >= 0; i--) begin
      if (kind_in_chan(ch, stop_kind_tbl[i]) && p >= stop_pos_tbl[i]) begin
        lo = i;
        break;
      end
    end
    return 1;
  endfunction

  function automatic logic [15:0] lerp(logic [15:0] a, logic [15:0] b, int lo, int hi,
                                        logic [31:0] p);
    logic [63:0] span, t;
    if (lo == hi) return b;
    span = 64'(stop_pos_tbl[hi]) - 64'(stop_pos_tbl[lo]);
    if (span == 0) return b;
    t = 64'(p) - 64'(stop_pos_tbl[lo]);
    return 16'(((span - t) * a + t * b) / span);
  endfunction

  function automatic void clear_path();
    dist_sum = '0;
    cursor = '{0, 0, 0};
  endfunction

  // advances the predictor by one request; returns 1 with a pixel if one results
  function automatic bit interpolate(req_t q, output pixel_t px);
    logic [32:0] sum;
    logic [63:0] ratio;
    logic [31:0] p;
    int n, lo, hi;
    px = '{default: '0};
    case (q.cmd)
      CMD_LOAD: begin
        stop_kind_tbl[q.idx] = q.kind;
        stop_pos_tbl[q.idx] = q.pos;
        stop_col_tbl[q.idx] = {q.red, q.green, q.blue, q.alpha};
        stop_wt_tbl[q.idx] = q.wt;
        return 0;
      end
      CMD_START: begin
        path_len = (q.total == 0) ? 32'd1 : q.total;
        clear_path();
        return 0;
      end
      CMD_SEGMENT: ;
      default: return 0;
    endcase
    sum = 33'(dist_sum) + 33'(q.seg);
    dist_sum = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    if (raw_units) begin
      p = dist_sum;
    end else begin
      ratio = {dist_sum, 16'd0} / path_len;
      p = (ratio > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : ratio[31:0];
    end
    n = (n_stops > 16) ? 16 : int'(n_stops);
    if (n < 2) begin
      if (q.fin) clear_path();
      return 0;
    end
    if (bracket(0, p, n, lo, hi)) begin
      px.red   = 8'(lerp(16'(stop_col_tbl[lo][31:24]), 16'(stop_col_tbl[hi][31:24]),
                         lo, hi, p));
      px.green = 8'(lerp(16'(stop_col_tbl[lo][23:16]), 16'(stop_col_tbl[hi][23:16]),
                         lo, hi, p));
      px.blue  = 8'(lerp(16'(stop_col_tbl[lo][15:8]), 16'(stop_col_tbl[hi][15:8]),
                         lo, hi, p));
    end
    if (bracket(1, p, n, lo, hi))
      px.alpha = 8'(lerp(16'(stop_col_tbl[lo][7:0]), 16'(stop_col_tbl[hi][7:0]), lo, hi, p));
    if (bracket(2, p, n, lo, hi))
      px.wt = lerp(stop_wt_tbl[lo], stop_wt_tbl[hi], lo, hi, p);
    px.eop = q.fin;
    if (q.fin) clear_path();
    return 1;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic send_request(req_t q, int gap, bit known, pixel_t typed);
    pixel_t px;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    command_i       <= q.cmd;
    stop_index_i    <= q.idx;
    stop_kind_i     <= q.kind;
    stop_pos_i      <= q.pos;
    stop_red_i      <= q.red;
    stop_green_i    <= q.green;
    stop_blue_i     <= q.blue;
    stop_alpha_i    <= q.alpha;
    stop_weight_i   <= q.wt;
    path_total_i    <= q.total;
    seg_length_i    <= q.seg;
    final_segment_i <= q.fin;
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
    if (interpolate(q, px)) pending_pixels.push_back(known ? typed : px);
  endtask

  task automatic write_reg(reg_e idx, logic [4:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(negedge clk_i); while (!cfg_ready_o);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == REG_UNIT_MODE) raw_units = data[0];
    else n_stops = data;
    @(posedge clk_i);
  endtask

  // segments with no result may still be in flight after the last pixel
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  function automatic req_t blank_req(cmd_e c);
    req_t q;
    q = '{cmd: c, kind: KIND_RGBA, default: '0};
    return q;
  endfunction

  function automatic req_t load_req(int idx, kind_e k, logic [31:0] pos, logic [7:0] c,
                                    logic [15:0] w);
    req_t q;
    q = blank_req(CMD_LOAD);
    q.idx = 4'(idx);
    q.kind = k;
    q.pos = pos;
    q.red = c; q.green = c; q.blue = c; q.alpha = c;
    q.wt = w;
    return q;
  endfunction

  function automatic req_t noise_req();
    req_t q;
    q.cmd   = cmd_e'($urandom_range(0, 3));
    q.idx   = 4'($urandom);
    q.kind  = kind_e'($urandom_range(0, 3));
    q.pos   = $urandom;
    q.red   = 8'($urandom);
    q.green = 8'($urandom);
    q.blue  = 8'($urandom);
    q.alpha = 8'($urandom);
    q.wt    = 16'($urandom);
    q.total = $urandom;
    q.seg   = $urandom;
    q.fin   = 1'($urandom);
    return q;
  endfunction

  // pixel receiver
  initial begin : receiver
    int stall;
    pixel_t want;
    forever begin
      stall = $urandom_range(0, 15);
      if ($urandom_range(0, 3) == 0) stall = 0;
      if (hold_cycles > 0) begin
        stall = hold_cycles;
        hold_cycles = 0;
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(negedge clk_i); while (!out_valid_o);
      if (pending_pixels.size() == 0) begin
        report_mismatch("unexpected pixel", 32'd1, 32'd0);
      end else begin
        want = pending_pixels.pop_front();
        if (out_red_o !== want.red)
          report_mismatch("red", 32'(out_red_o), 32'(want.red));
        if (out_green_o !== want.green)
          report_mismatch("green", 32'(out_green_o), 32'(want.green));
        if (out_blue_o !== want.blue)
          report_mismatch("blue", 32'(out_blue_o), 32'(want.blue));
        if (out_alpha_o !== want.alpha)
          report_mismatch("alpha", 32'(out_alpha_o), 32'(want.alpha));
        if (out_weight_o !== want.wt)
          report_mismatch("weight", 32'(out_weight_o), 32'(want.wt));
        if (end_of_path_o !== want.eop)
          report_mismatch("end_of_path", 32'(end_of_path_o), 32'(want.eop));
      end
      @(posedge clk_i);
    end
  end

  initial begin : watchdog
    #20ms;
    $display("gradient_stop_interpolator test failed");
    $finish;
  end

  initial begin : stimulus
    row_t rows [$];
    row_t r;
    req_t q;
    pixel_t none;
    int sent, i, segs, gap;
    logic [4:0] counts [6];
    errors = 0;
    hold_cycles = 0;
    path_len = 32'd1;
    raw_units = 1'b0;
    n_stops = '0;
    clear_path();
    none = '{default: '0};
    counts = '{5'd16, 5'd2, 5'd0, 5'd31, 5'd1, 5'd9};

    // fills every slot, so no later search touches an unwritten entry
    rows.push_back('{load_req(0, KIND_RGBA, 32'h0, 8'h00, 16'h0000), 0, none});
    rows.push_back('{load_req(1, KIND_WEIGHT, 32'h0, 8'h00, 16'h0000), 0, none});
    rows.push_back('{load_req(2, KIND_RGB, 32'h1_0000, 8'hFF, 16'h5555), 0, none});
    rows.push_back('{load_req(3, KIND_ALPHA, 32'h1_0000, 8'hFF, 16'h0000), 0, none});
    rows.push_back('{load_req(4, KIND_WEIGHT, 32'h1_0000, 8'h00, 16'hFFFF), 0, none});
    for (i = 5; i < 15; i++)
      rows.push_back('{load_req(i, KIND_RGBA, 32'hFFFF_FFFF, 8'hFF, 16'h1234), 0, none});
    rows.push_back('{load_req(15, KIND_WEIGHT, 32'hFFFF_FFFF, 8'h00, 16'hFFFF), 0, none});
    // too few stops: no pixel
    q = blank_req(CMD_SEGMENT);
    q.seg = 32'h8000;
    rows.push_back('{q, 0, none});
    // raw units, sixteen stops from here on
    q = blank_req(CMD_START);
    rows.push_back('{q, 0, none});
    q = blank_req(CMD_SEGMENT);
    rows.push_back('{q, 1, '{8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b0}});
    q.seg = 32'h1_0000;
    rows.push_back('{q, 1, '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 1'b0}});
    rows.push_back('{blank_req(CMD_NONE), 0, none});
    q.seg = 32'hFFFF_FFFF;
    q.fin = 1'b1;
    rows.push_back('{q, 1, '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 1'b1}});
    q = blank_req(CMD_START);
    q.total = 32'h2_0000;
    rows.push_back('{q, 0, none});
    q = blank_req(CMD_SEGMENT);
    q.seg = 32'h8000;
    rows.push_back('{q, 0, none});
    q.seg = 32'h4321;
    q.fin = 1'b1;
    rows.push_back('{q, 0, none});

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    for (i = 0; i < rows.size(); i++) begin
      r = rows[i];
      if (i == 17) begin
        drain();
        write_reg(REG_UNIT_MODE, 5'd1);
        write_reg(REG_STOP_COUNT, 5'd16);
      end
      send_request(r.req, $urandom_range(0, 15), r.known, r.pix);
    end

    sent = 0;
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      write_reg(REG_UNIT_MODE, 5'(ph % 2));
      write_reg(REG_STOP_COUNT, counts[ph]);
      if (ph == 1) hold_cycles = 600;
      while (sent < (ph + 1) * 150) begin
        if ($urandom_range(0, 9) == 0) begin
          q = noise_req();
          send_request(q, $urandom_range(0, 15), 0, none);
          sent++;
          continue;
        end
        // reshuffle a few stops, then a well-formed path
        repeat ($urandom_range(0, 3)) begin
          q = noise_req();
          q.cmd = CMD_LOAD;
          if ($urandom_range(0, 3) != 0) q.pos = $urandom_range(0, 32'h3_0000);
          send_request(q, $urandom_range(0, 15), 0, none);
          sent++;
        end
        q = noise_req();
        q.cmd = CMD_START;
        if ($urandom_range(0, 3) != 0) q.total = $urandom_range(32'h1000, 32'h4_0000);
        send_request(q, $urandom_range(0, 15), 0, none);
        sent++;
        segs = $urandom_range(1, 10);
        for (int s = 0; s < segs; s++) begin
          q = noise_req();
          q.cmd = CMD_SEGMENT;
          q.fin = (s == segs - 1) && ($urandom_range(0, 4) != 0);
          if ($urandom_range(0, 7) != 0) q.seg = $urandom_range(0, 32'h1_0000) >> (ph % 2);
          // back-to-back bursts with no idle cycles now and then
          gap = (ph == 1 || ph == 5) ? 0 : $urandom_range(0, 15);
          send_request(q, gap, 0, none);
          sent++;
        end
      end
    end

    drain();
    if (errors == 0) begin
      $display("gradient_stop_interpolator test passed");
    end else begin
      $display("gradient_stop_interpolator test failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/gsi_pkg.sv
src/gsi_ctrl.sv
src/gsi_dp.sv
src/gradient_stop_interpolator.sv
tb/gradient_stop_interpolator_test.sv
